@@ design/pncm_pkg.sv @@
package pncm_pkg;

  localparam int PAL_DEPTH  = 256;
  localparam int PAL_AW     = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
  localparam int CAND_COUNT = 8;
  localparam int CAND_W     = (CAND_COUNT > 1) ? $clog2(CAND_COUNT) : 1;

  localparam logic [8:0]  PAL_DEPTH_L = 9'(PAL_DEPTH);
  localparam logic [17:0] FAR_DIST    = 18'd195076;
  localparam logic [16:0] HSV_ONE     = 17'd65536;
  localparam logic [18:0] HSV_SCALE   = 19'd10000;

  typedef struct packed {
    logic        start;
    logic        is_target;
    logic [23:0] color;
  } hsv_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] gap;
  } hsv_rsp_t;

  function automatic logic [16:0] quarter_sine(input logic [3:0] i);
    logic [16:0] q;
    case (i)
      4'd0:    q = 17'd0;
      4'd1:    q = 17'd8554;
      4'd2:    q = 17'd16962;
      4'd3:    q = 17'd25080;
      4'd4:    q = 17'd32768;
      4'd5:    q = 17'd39896;
      4'd6:    q = 17'd46341;
      4'd7:    q = 17'd51993;
      4'd8:    q = 17'd56756;
      4'd9:    q = 17'd60547;
      4'd10:   q = 17'd63303;
      4'd11:   q = 17'd64975;
      default: q = 17'd65536;
    endcase
    return q;
  endfunction

  // k is an angle step below 48 (7.5 degrees each); result in signed Q2.16 format
  function automatic logic signed [18:0] sine_step(input logic [5:0] k);
    logic [16:0] m;
    logic        neg;
    if (k < 6'd12) begin
      m = quarter_sine(k[3:0]);
      neg = 1'b0;
    end else if (k < 6'd24) begin
      m = quarter_sine(4'(6'd24 - k));
      neg = 1'b0;
    end else if (k < 6'd36) begin
      m = quarter_sine(4'(k - 6'd24));
      neg = 1'b1;
    end else begin
      m = quarter_sine(4'(6'd48 - k));
      neg = 1'b1;
    end
    return neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
  endfunction

endpackage

@@ design/pncm_ram.sv @@
module pncm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/pncm_hsv.sv @@
module pncm_hsv
  import pncm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  hsv_req_t req,
  output hsv_rsp_t rsp
);

  typedef enum logic [3:0] {
    H_IDLE, H_DIV, H_MX, H_MY, H_DIFF, H_SQX, H_SQY, H_SQV, H_SCALE
  } hstate_t;

  hstate_t state_r;
  logic [23:0] col_r;
  logic        tgt_r;
  logic [1:0]  phase_r;
  logic [4:0]  cnt_r;
  logic [7:0]  rem_r;
  logic [15:0] q_r;
  logic [18:0] h_r;
  logic [16:0] s_r, v_r;
  logic signed [34:0] x_r, y_r, tx_r, ty_r;
  logic [16:0] tv_r;
  logic signed [18:0] dx_r, dy_r;
  logic signed [17:0] dv_r;
  logic [35:0] sum_r;
  logic [16:0] dist_r;
  logic        done_r;

  // color decode
  logic [7:0]  cr, cg, cb, hn, hd, mn, sec, mx;
  logic [2:0]  base;
  logic        sub, gray;
  logic [16:0] vq;

  always_comb begin
    cr = col_r[23:16];
    cg = col_r[15:8];
    cb = col_r[7:0];
    gray = (cr == cg) && (cg == cb);
    if (cr <= cg && cr <= cb) begin
      mn = cr;
      if (cg >= cb) begin
        hn = cb; hd = cg; base = 3'd2; sub = 1'b0; sec = cb; mx = cg;
      end else begin
        hn = cg; hd = cb; base = 3'd4; sub = 1'b1; sec = cg; mx = cb;
      end
    end else if (cg <= cr && cg <= cb) begin
      mn = cg;
      if (cr >= cb) begin
        hn = cb; hd = cr; base = 3'd6; sub = 1'b1; sec = cb; mx = cr;
      end else begin
        hn = cr; hd = cb; base = 3'd4; sub = 1'b0; sec = cr; mx = cb;
      end
    end else begin
      mn = cb;
      if (cr >= cg) begin
        hn = cg; hd = cr; base = 3'd0; sub = 1'b0; sec = cg; mx = cr;
      end else begin
        hn = cr; hd = cg; base = 3'd2; sub = 1'b1; sec = cr; mx = cg;
      end
    end
    // (mx << 16) / 255 = 257 * mx, plus one when mx is 255
    vq = {1'b0, mx, mx} + {16'd0, (mx == 8'hff)};
  end

  // bit-serial divider: one quotient bit a cycle
  logic [7:0]  div_a, div_b;
  logic [8:0]  trial, rem_d;
  logic        ge;
  logic [16:0] quot;

  always_comb begin
    case (phase_r)
      2'd0:    begin div_a = hn; div_b = hd; end
      default: begin div_a = mn; div_b = sec; end
    endcase
    trial = (cnt_r == 5'd0) ? {1'b0, div_a} : {rem_r, 1'b0};
    ge    = trial >= {1'b0, div_b};
    rem_d = ge ? trial - {1'b0, div_b} : trial;
    quot  = {q_r, ge};
  end

  // angle step and shared multiplier
  logic [19:0] hsum;
  logic [5:0]  k, kc;
  logic [6:0]  kc_raw;
  logic signed [36:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [55:0] prod;
  logic signed [35:0] ddx, ddy;
  logic signed [19:0] qx, qy;

  always_comb begin
    hsum   = {1'b0, h_r} + 20'd4096;
    k      = (hsum[18:13] >= 6'd48) ? 6'd0 : hsum[18:13];
    kc_raw = {1'b0, k} + 7'd12;
    kc     = (kc_raw >= 7'd48) ? 6'(kc_raw - 7'd48) : kc_raw[5:0];
    case (state_r)
      H_MX:    begin mul_a = $signed({20'd0, s_r}); mul_b = sine_step(kc); end
      H_MY:    begin mul_a = $signed({20'd0, s_r}); mul_b = sine_step(k); end
      H_SQX:   begin mul_a = 37'(dx_r); mul_b = dx_r; end
      H_SQY:   begin mul_a = 37'(dy_r); mul_b = dy_r; end
      H_SQV:   begin mul_a = 37'(dv_r); mul_b = 19'(dv_r); end
      H_SCALE: begin mul_a = $signed({1'b0, sum_r}); mul_b = $signed(HSV_SCALE); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod = mul_a * mul_b;
    ddx  = 36'(x_r) - 36'(tx_r);
    ddy  = 36'(y_r) - 36'(ty_r);
    // truncate toward zero
    qx   = 20'(ddx >>> 16) + 20'(ddx[35] && (ddx[15:0] != 16'd0));
    qy   = 20'(ddy >>> 16) + 20'(ddy[35] && (ddy[15:0] != 16'd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == H_MY && tgt_r) || (state_r == H_SCALE);
      unique case (state_r)
        H_IDLE: begin
          if (req.start) begin
            col_r   <= req.color;
            tgt_r   <= req.is_target;
            phase_r <= 2'd0;
            cnt_r   <= 5'd0;
            state_r <= H_DIV;
          end
        end
        H_DIV: begin
          rem_r <= rem_d[7:0];
          q_r   <= quot[15:0];
          cnt_r <= (cnt_r == 5'd16) ? 5'd0 : cnt_r + 5'd1;
          if (cnt_r == 5'd16) begin
            if (phase_r == 2'd0) begin
              h_r <= gray ? {2'b00, HSV_ONE} :
                     sub ? {base, 16'd0} - {2'b00, quot} :
                           {base, 16'd0} + {2'b00, quot};
              phase_r <= 2'd1;
            end else begin
              s_r     <= gray ? 17'd0 : (sec == 8'd0) ? HSV_ONE : HSV_ONE - quot;
              v_r     <= vq;
              state_r <= H_MX;
            end
          end
        end
        H_MX: begin
          x_r     <= prod[34:0];
          state_r <= H_MY;
        end
        H_MY: begin
          if (tgt_r) begin
            tx_r    <= x_r;
            ty_r    <= prod[34:0];
            tv_r    <= v_r;
            state_r <= H_IDLE;
          end else begin
            y_r     <= prod[34:0];
            state_r <= H_DIFF;
          end
        end
        H_DIFF: begin
          dx_r    <= qx[18:0];
          dy_r    <= qy[18:0];
          dv_r    <= $signed({1'b0, v_r}) - $signed({1'b0, tv_r});
          state_r <= H_SQX;
        end
        H_SQX: begin
          sum_r   <= prod[35:0];
          state_r <= H_SQY;
        end
        H_SQY: begin
          sum_r   <= sum_r + prod[35:0];
          state_r <= H_SQV;
        end
        H_SQV: begin
          sum_r   <= sum_r + prod[35:0];
          state_r <= H_SCALE;
        end
        H_SCALE: begin
          dist_r  <= prod[48:32];
          state_r <= H_IDLE;
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.gap  = dist_r;

endmodule

@@ design/palette_nearest_color_match.sv @@
// Palette nearest-color search. Load items (tuser mode 0) write one palette
// entry and its reserved mark and give no result. A query item (mode 1)
// gives one result: the default index if its reserved flag is set,
// otherwise the best match. A regular query first scans entries
// 0..palette_size-1 at one per cycle (palette_size saturates at the
// palette depth) through the color RAM read port, then lets the scan
// pipeline drain, keeping the eight nearest in squared RGB distance. It then
// runs the shared HSV unit nine times (the target once, each candidate once);
// each run is dominated by two bit-serial divisions. Input is not ready while
// a query is at work. The reserved marks sit in flip-flops cleared by reset,
// so no clearing pass is needed; color entries are undefined until written
// and must be loaded before any query that reads them. The palette_size
// register may be written only while the block is idle.
module palette_nearest_color_match
  import pncm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_index, red, green, blue
  input  logic [1:0]  in_tuser,   // mode, reserved_flag
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // match_index
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data    // palette_size
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_TGT, S_TGT_W, S_CRD, S_CST, S_CW, S_FINISH
  } state_t;

  state_t state_r;
  logic [8:0]  size_r, limit_r, scan_r;
  logic [23:0] target_r;
  logic [7:0]  best_r, cur_idx_r;
  logic [16:0] best_d_r;
  logic [CAND_W-1:0] cc_r;
  logic [17:0] cand_dist_r [CAND_COUNT];
  logic [7:0]  cand_idx_r  [CAND_COUNT];
  logic [PAL_DEPTH-1:0] resv_r;
  logic        out_tvalid_r;
  logic [7:0]  out_data_r;

  // scan pipeline
  logic        p1_vld_r, p2_vld_r;
  logic [7:0]  p1_idx_r, p2_idx_r;
  logic [17:0] p2_dist_r;

  logic [7:0]  in_idx, in_r, in_g, in_b;
  logic        in_mode, in_resv, in_acc;
  assign in_idx  = in_tdata[7:0];
  assign in_r    = in_tdata[15:8];
  assign in_g    = in_tdata[23:16];
  assign in_b    = in_tdata[31:24];
  assign in_mode = in_tuser[0];
  assign in_resv = in_tuser[1];
  assign in_acc  = in_tvalid && in_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // palette color RAM, written by load items
  logic              ram_we;
  logic [PAL_AW-1:0] ram_raddr;
  logic [23:0]       ram_rdata;

  assign ram_we = in_acc && !in_mode && ({1'b0, in_idx} < PAL_DEPTH_L);

  always_comb begin
    if (state_r == S_CRD) begin
      ram_raddr = PAL_AW'(cand_idx_r[cc_r]);
    end else begin
      ram_raddr = scan_r[PAL_AW-1:0];
    end
  end

  pncm_ram #(.WIDTH(24), .DEPTH(PAL_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (PAL_AW'(in_idx)),
    .wdata ({in_r, in_g, in_b}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // squared RGB distance of the entry read last cycle
  logic signed [8:0] dr, dg, db;
  logic [17:0] rgb_d;
  always_comb begin
    dr = $signed({1'b0, target_r[23:16]}) - $signed({1'b0, ram_rdata[23:16]});
    dg = $signed({1'b0, target_r[15:8]})  - $signed({1'b0, ram_rdata[15:8]});
    db = $signed({1'b0, target_r[7:0]})   - $signed({1'b0, ram_rdata[7:0]});
    rgb_d = 18'(dr * dr) + 18'(dg * dg) + 18'(db * db);
  end

  // sorted insert: strict compare keeps ties on the earlier entry
  logic [CAND_COUNT-1:0] lt;
  always_comb begin
    for (int i = 0; i < CAND_COUNT; i++) begin
      lt[i] = p2_dist_r < cand_dist_r[i];
    end
  end

  // shared HSV unit
  hsv_req_t hsv_req;
  hsv_rsp_t hsv_rsp;
  logic     cur_in_range;

  assign cur_in_range     = {1'b0, cur_idx_r} < PAL_DEPTH_L;
  assign hsv_req.start    = (state_r == S_TGT) || (state_r == S_CST);
  assign hsv_req.is_target = (state_r == S_TGT);
  assign hsv_req.color    = (state_r == S_TGT) ? target_r :
                            (cur_in_range ? ram_rdata : 24'd0);

  pncm_hsv u_hsv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hsv_req),
    .rsp   (hsv_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      size_r       <= PAL_DEPTH_L;
      resv_r       <= '0;
      out_tvalid_r <= 1'b0;
      p1_vld_r     <= 1'b0;
      p2_vld_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_data;
      end
      // drop the result once taken, unless a new one replaces it
      if (out_tvalid_r && out_tready && state_r != S_FINISH) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (!in_mode) begin
              if (ram_we) begin
                resv_r[PAL_AW'(in_idx)] <= in_resv;
              end
            end else begin
              target_r <= {in_r, in_g, in_b};
              if (in_resv) begin
                best_r  <= in_idx;
                state_r <= S_FINISH;
              end else begin
                for (int i = 0; i < CAND_COUNT; i++) begin
                  cand_dist_r[i] <= FAR_DIST;
                  cand_idx_r[i]  <= in_idx;
                end
                limit_r <= (size_r > PAL_DEPTH_L) ? PAL_DEPTH_L : size_r;
                scan_r  <= 9'd0;
                state_r <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          // issue one read a cycle, skip reserved entries
          p1_vld_r <= (scan_r < limit_r) && !resv_r[scan_r[PAL_AW-1:0]];
          p1_idx_r <= scan_r[7:0];
          if (scan_r < limit_r) begin
            scan_r <= scan_r + 9'd1;
          end
          p2_vld_r  <= p1_vld_r;
          p2_idx_r  <= p1_idx_r;
          p2_dist_r <= rgb_d;
          if (p2_vld_r) begin
            for (int i = 0; i < CAND_COUNT; i++) begin
              if (lt[i]) begin
                if (i == 0) begin
                  cand_dist_r[i] <= p2_dist_r;
                  cand_idx_r[i]  <= p2_idx_r;
                end else if (!lt[(i == 0) ? 0 : i - 1]) begin
                  cand_dist_r[i] <= p2_dist_r;
                  cand_idx_r[i]  <= p2_idx_r;
                end else begin
                  cand_dist_r[i] <= cand_dist_r[(i == 0) ? 0 : i - 1];
                  cand_idx_r[i]  <= cand_idx_r[(i == 0) ? 0 : i - 1];
                end
              end
            end
          end
          if (scan_r == limit_r && !p1_vld_r && !p2_vld_r) begin
            state_r <= S_TGT;
          end
        end
        S_TGT: begin
          state_r <= S_TGT_W;
        end
        S_TGT_W: begin
          if (hsv_rsp.done) begin
            cc_r    <= '0;
            state_r <= S_CRD;
          end
        end
        S_CRD: begin
          cur_idx_r <= cand_idx_r[cc_r];
          state_r   <= S_CST;
        end
        S_CST: begin
          state_r <= S_CW;
        end
        S_CW: begin
          if (hsv_rsp.done) begin
            // ties keep the earlier candidate
            if (cc_r == '0 || hsv_rsp.gap < best_d_r) begin
              best_d_r <= hsv_rsp.gap;
              best_r   <= cur_idx_r;
            end
            if (cc_r == CAND_W'(CAND_COUNT - 1)) begin
              state_r <= S_FINISH;
            end else begin
              cc_r    <= cc_r + CAND_W'(1);
              state_r <= S_CRD;
            end
          end
        end
        S_FINISH: begin
          // hold the result until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_data_r   <= best_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a query closes the input until its result is produced
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0]) |=> !in_tready)
    else $error("input ready right after a query item");

  // scan address never runs past the limit
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_r <= limit_r))
    else $error("scan address beyond limit");

  // the HSV unit only reports while a run is awaited
  a_hsv_done: assert property (@(posedge clk) disable iff (!rst_n)
    hsv_rsp.done |-> (state_r == S_TGT_W || state_r == S_CW))
    else $error("unexpected HSV completion");

  // candidate list stays sorted: the first is never farther than the last
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cand_dist_r[0] <= cand_dist_r[CAND_COUNT-1]))
    else $error("candidate list out of order");

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pncm_pkg::*;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam int   STALL_LIMIT = 6000;

  // idling patterns
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] slot;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       resv;
  } item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // entry_index, red, green, blue
  logic [1:0]  in_tuser = '0;   // mode, reserved_flag
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // match_index
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;   // palette_size

  palette_nearest_color_match DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  item_t       pending_items[$];
  logic [7:0]  expected_matches[$];
  item_t       cur_item;
  logic        in_fire = 1'b0;
  idle_t       idle_mode = IDLE_NONE;
  int          errors = 0;
  int          quiet_cycles = 0;

  // bench copy of the block state
  logic [23:0] pal_color[PAL_DEPTH];
  logic        pal_resv[PAL_DEPTH];
  logic [8:0]  size_shadow = 9'd256;

  function automatic longint sine_of(input int k);
    int qs[13] = '{0, 8554, 16962, 25080, 32768, 39896, 46341,
                   51993, 56756, 60547, 63303, 64975, 65536};
    int q;
    int r;
    k = k % 48;
    q = k / 12;
    r = k % 12;
    case (q)
      0: return qs[r];
      1: return qs[12 - r];
      2: return -qs[r];
      default: return -qs[12 - r];
    endcase
  endfunction

  function automatic longint unsigned ratio16(input longint unsigned a,
                                              input longint unsigned b);
    if (b == 0) return 65536;
    return (a << 16) / b;
  endfunction

  // color -> point in the hue/saturation plane plus value
  function automatic void hsv_point(input logic [23:0] c, output longint x,
                                    output longint y, output longint v);
    longint unsigned r, g, b, h, s, mx;
    int k;
    r = c[23:16]; g = c[15:8]; b = c[7:0];
    if (r == g && r == b) begin
      h = 65536; s = 0; mx = r;
    end else if (r <= g && r <= b) begin
      if (g >= b) begin
        h = 2*65536 + ratio16(b, g); s = b ? 65536 - ratio16(r, b) : 65536; mx = g;
      end else begin
        h = 4*65536 - ratio16(g, b); s = g ? 65536 - ratio16(r, g) : 65536; mx = b;
      end
    end else if (g <= r && g <= b) begin
      if (r >= b) begin
        h = 6*65536 - ratio16(b, r); s = b ? 65536 - ratio16(g, b) : 65536; mx = r;
      end else begin
        h = 4*65536 + ratio16(r, b); s = r ? 65536 - ratio16(g, r) : 65536; mx = b;
      end
    end else begin
      if (r >= g) begin
        h = ratio16(g, r); s = g ? 65536 - ratio16(b, g) : 65536; mx = r;
      end else begin
        h = 2*65536 - ratio16(r, g); s = r ? 65536 - ratio16(b, r) : 65536; mx = g;
      end
    end
    k = int'(((h + 4096) >> 13) % 48);
    x = longint'(s) * sine_of(k + 12);
    y = longint'(s) * sine_of(k);
    v = longint'((mx << 16) / 255);
  endfunction

  function automatic longint unsigned hsv_gap(input logic [23:0] a, input logic [23:0] b);
    longint x1, y1, v1, x2, y2, v2, dx, dy, dv;
    longint unsigned sum;
    hsv_point(a, x1, y1, v1);
    hsv_point(b, x2, y2, v2);
    dx = (x2 - x1) / 65536;
    dy = (y2 - y1) / 65536;
    dv = v2 - v1;
    sum = longint'(dx*dx) + longint'(dy*dy) + longint'(dv*dv);
    return (sum * 10000) >> 32;
  endfunction

  function automatic int rgb_gap(input logic [23:0] a, input logic [23:0] b);
    int dr, dg, db;
    dr = int'(a[23:16]) - int'(b[23:16]);
    dg = int'(a[15:8]) - int'(b[15:8]);
    db = int'(a[7:0]) - int'(b[7:0]);
    return dr*dr + dg*dg + db*db;
  endfunction

  // apply one accepted item; a query pushes its expected match
  task automatic search_palette(input item_t it);
    int cd[CAND_COUNT];
    int ci[CAND_COUNT];
    int lim, nd, nc, td, tc, best;
    longint unsigned bd, t;
    logic [23:0] tgt;
    tgt = {it.red, it.green, it.blue};
    if (it.mode == MODE_LOAD) begin
      pal_color[it.slot] = tgt;
      pal_resv[it.slot] = it.resv;
      return;
    end
    if (it.resv) begin
      expected_matches.push_back(it.slot);
      return;
    end
    for (int i = 0; i < CAND_COUNT; i++) begin
      cd[i] = 195076; ci[i] = it.slot;
    end
    lim = (size_shadow > PAL_DEPTH) ? PAL_DEPTH : int'(size_shadow);
    for (int e = 0; e < lim; e++) begin
      if (pal_resv[e]) continue;
      nd = rgb_gap(tgt, pal_color[e]);
      if (nd >= cd[CAND_COUNT-1]) continue;
      nc = e;
      // insert, ties stay behind earlier entries
      for (int i = 0; i < CAND_COUNT; i++) begin
        if (nd < cd[i]) begin
          td = cd[i]; tc = ci[i];
          cd[i] = nd; ci[i] = nc;
          nd = td; nc = tc;
        end
      end
    end
    best = ci[0];
    bd = hsv_gap(tgt, pal_color[ci[0]]);
    for (int i = 1; i < CAND_COUNT; i++) begin
      t = hsv_gap(tgt, pal_color[ci[i]]);
      if (t < bd) begin
        bd = t; best = ci[i];
      end
    end
    expected_matches.push_back(8'(best));
  endtask

  // record input handshakes and predict
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) search_palette(cur_item);
  end

  // driver: advance at the falling edge, hold while not accepted
  always @(negedge clk) begin
    if (rst_n && (in_fire || !in_tvalid)) begin
      if (pending_items.size() > 0 &&
          !((idle_mode == IDLE_SEND && $urandom_range(99) < 68) ||
            (idle_mode == IDLE_BOTH && $urandom_range(99) < 11))) begin
        cur_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {cur_item.blue, cur_item.green, cur_item.red, cur_item.slot};
        in_tuser <= {cur_item.resv, cur_item.mode};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else case (idle_mode)
      IDLE_RECV: out_tready <= $urandom_range(99) >= 68;
      IDLE_BOTH: out_tready <= $urandom_range(99) >= 11;
      default:   out_tready <= 1'b1;
    endcase
  end

  // monitor: compare each result with the oldest expected match
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected match_index, expected none, actual %0d", $time, out_tdata);
        errors++;
      end else begin
        if (out_tdata !== expected_matches[0]) begin
          $display("%0t: match_index mismatch, expected %0d, actual %0d",
                   $time, expected_matches[0], out_tdata);
          errors++;
        end
        void'(expected_matches.pop_front());
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic item_t random_item();
    item_t it;
    it.mode  = ($urandom_range(99) < 45) ? MODE_LOAD : MODE_QUERY;
    it.slot  = 8'($urandom);
    it.red   = 8'($urandom);
    it.green = 8'($urandom);
    it.blue  = 8'($urandom);
    it.resv  = ($urandom_range(9) == 0);
    // aim some queries at palette colors to force equal distances
    if (it.mode == MODE_QUERY && $urandom_range(3) == 0)
      {it.red, it.green, it.blue} = pal_color[$urandom_range(PAL_DEPTH-1)];
    return it;
  endfunction

  task automatic push_item(input logic mode, input logic [7:0] slot,
                           input logic [23:0] c, input logic resv);
    pending_items.push_back('{mode, slot, c[23:16], c[15:8], c[7:0], resv});
  endtask

  // wait until all items are taken and all matches have arrived
  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() > 0 || in_tvalid || expected_matches.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(input logic [8:0] sz);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    do @(posedge clk); while (!cfg_ready);
    size_shadow = sz;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [8:0] sizes[6] = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd9, 9'd40};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    write_size(9'd256);
    // fill every color entry before any query reads it
    for (int e = 0; e < PAL_DEPTH; e++) push_item(MODE_LOAD, 8'(e), 24'($urandom), 1'b0);
    drain();
    // directed: extremes, reserved paths, gray and saturated colors
    push_item(MODE_QUERY, 8'd0,   24'h000000, 1'b0);
    push_item(MODE_QUERY, 8'd255, 24'hffffff, 1'b0);
    push_item(MODE_QUERY, 8'd255, 24'h123456, 1'b1);
    push_item(MODE_QUERY, 8'd0,   24'hffffff, 1'b1);
    push_item(MODE_LOAD,  8'd255, 24'hff0000, 1'b0);
    push_item(MODE_LOAD,  8'd0,   24'h00ff00, 1'b1);
    push_item(MODE_LOAD,  8'd1,   24'h808080, 1'b0);
    push_item(MODE_LOAD,  8'd2,   24'h808080, 1'b0);
    push_item(MODE_QUERY, 8'd7,   24'h808080, 1'b0);
    push_item(MODE_QUERY, 8'd9,   24'h00ff00, 1'b0);
    push_item(MODE_QUERY, 8'd3,   24'hff0000, 1'b0);
    push_item(MODE_QUERY, 8'd4,   24'h0000ff, 1'b0);
    push_item(MODE_QUERY, 8'd5,   24'hff00ff, 1'b0);
    push_item(MODE_QUERY, 8'd6,   24'h00ffff, 1'b0);
    push_item(MODE_QUERY, 8'd8,   24'hffff00, 1'b0);
    push_item(MODE_LOAD,  8'd0,   24'h010203, 1'b0);
    push_item(MODE_QUERY, 8'd200, 24'hfe01fe, 1'b0);
    drain();
    for (int p = 0; p < 6; p++) begin
      write_size(p == 5 ? 9'($urandom_range(2, 255)) : sizes[p]);
      for (int n = 0; n < 255; n++) begin
        idle_mode = idle_t'(((n / 75) + p) % 4);
        pending_items.push_back(random_item());
        // hold generation so idle patterns line up with traffic
        if (pending_items.size() > 8) wait (pending_items.size() <= 4);
      end
      drain();
      idle_mode = IDLE_NONE;
    end
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
